[sv/stream_find_replace_top_macros.svh]
// assertion macros for the stream find-and-replace block
// used by the top level; expects signals named clock and reset in scope
`ifndef STREAM_FIND_REPLACE_TOP_MACROS_SVH
`define STREAM_FIND_REPLACE_TOP_MACROS_SVH

// property checked at every clock edge outside reset
`define SFR_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// condition in one cycle implies a consequence in the next
`define SFR_CHECK_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error(msg);

`endif

[sv/sfr_pkg.sv]
// shared types and constants of the stream find-and-replace block
// no dependencies; imported by sfr_cell, stream_find_replace_top and the testbench
package sfr_pkg;

   localparam int BYTE_W  = 8;
   localparam int CFG_W   = 64;
   localparam int CNT_W   = 24;
   localparam int CSR_IW  = 3;
   localparam int LEN_W   = 4;

   localparam logic [CNT_W-1:0] CNT_MAX  = 24'hFFFFFF;
   localparam logic [LEN_W-1:0] REPL_MAX = 4'd8;

   // register indexes of the configuration port
   localparam logic [CSR_IW-1:0] REG_PAT_LEN    = 3'd0;
   localparam logic [CSR_IW-1:0] REG_PAT_BYTES  = 3'd1;
   localparam logic [CSR_IW-1:0] REG_REPL_LEN   = 3'd2;
   localparam logic [CSR_IW-1:0] REG_REPL_BYTES = 3'd3;
   localparam logic [CSR_IW-1:0] REG_START      = 3'd4;
   localparam logic [CSR_IW-1:0] REG_LIMIT      = 3'd5;

   // per-cell window control
   typedef struct packed {
      logic load;
      logic shift;
   } sfr_cell_ctl_type;

endpackage

[sv/sfr_cell.sv]
// one window cell: holds a text byte, compares it with its pattern byte
// and passes the prefix-match flag and its byte down the chain; uses sfr_pkg
module sfr_cell (
   input  logic                        clock,
   input  logic [sfr_pkg::BYTE_W-1:0]  pat_byte,
   input  logic [sfr_pkg::BYTE_W-1:0]  in_byte,
   input  logic [sfr_pkg::BYTE_W-1:0]  right_byte,
   input  sfr_pkg::sfr_cell_ctl_type   ctl,
   input  logic                        valid,
   input  logic                        ok_in,
   output logic                        ok_out,
   output logic                        in_eq,
   output logic [sfr_pkg::BYTE_W-1:0]  byte_out
);
   import sfr_pkg::*;

   logic [BYTE_W-1:0] byte_ff, byte_in;

   // next byte: new text byte, neighbor's byte on a shift, or hold
   always_comb begin
      if (ctl.load) begin
         byte_in = in_byte;
      end else if (ctl.shift) begin
         byte_in = right_byte;
      end else begin
         byte_in = byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   // prefix match chain; an empty cell does not break it
   assign ok_out   = ok_in & (~valid | (byte_ff == pat_byte));
   assign in_eq    = (in_byte == pat_byte);
   assign byte_out = byte_ff;

endmodule

[sv/stream_find_replace_top.sv]
// top level of the stream find-and-replace block: configuration registers,
// window cell chain, match control and output register; uses sfr_pkg, sfr_cell
// and stream_find_replace_top_macros.svh
//
// Usage:
//  - csr channel writes one register per item (index 0..5); any write clears
//    the text in progress. Write only while the block is idle.
//  - req channel carries one text byte per item, req_text_end on the last one.
//  - rsp channel returns output bytes; rsp_byte_valid is 0 only on a bare end
//    item, rsp_out_end marks the last item produced for a text.
//  - Results are registered: the first item of an input byte appears the cycle
//    after that byte is accepted.
//  - A byte completing an occurrence yields L output bytes, L being the
//    replacement length (or pattern length when copied). A mismatch releases
//    held bytes from the head of the window, and the final byte flushes every
//    byte still held; no new byte is taken meanwhile. The single output
//    register moves one item per cycle while rsp_ready does not hold it.
//  - When rsp_ready is low with an item in the output register, the register holds and req_ready drops.
//  - Reset clears the text state and loads register defaults (start 1,
//    limit unlimited, empty pattern and replacement).
`include "stream_find_replace_top_macros.svh"

module stream_find_replace_top #(
   parameter int MAX_PATTERN = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [sfr_pkg::CSR_IW-1:0]  csr_index,
   input  logic [sfr_pkg::CFG_W-1:0]   csr_data,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [sfr_pkg::BYTE_W-1:0]  req_text_byte,
   input  logic                        req_text_end,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [sfr_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                        rsp_byte_valid,
   output logic                        rsp_out_end
);
   import sfr_pkg::*;

   localparam int CW = $clog2(MAX_PATTERN + 1);
   localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   // configuration registers
   logic [LEN_W-1:0]  pat_len_ff;
   logic [CFG_W-1:0]  pat_bytes_ff;
   logic [LEN_W-1:0]  repl_len_ff;
   logic [CFG_W-1:0]  repl_bytes_ff;
   logic [CNT_W-1:0]  start_ff;
   logic [CNT_W-1:0]  limit_ff;

   // text state
   logic [CW-1:0]     fill_ff, fill_in;
   logic [LEN_W-1:0]  burst_left_ff, burst_left_in;
   logic [2:0]        burst_idx_ff, burst_idx_in;
   logic              burst_repl_ff, burst_repl_in;
   logic              end_pend_ff, end_pend_in;
   logic [CNT_W-1:0]  found_ff, found_in;
   logic [CNT_W-1:0]  replaced_ff, replaced_in;
   logic              skip_ff, skip_in;

   // output register
   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] out_byte_ff;
   logic              byte_valid_ff;
   logic              out_end_ff;

   // cell chain signals
   logic [BYTE_W-1:0]    cell_byte [MAX_PATTERN];
   logic [BYTE_W-1:0]    right_byte [MAX_PATTERN];
   sfr_cell_ctl_type     cell_ctl [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] cell_valid;
   logic [MAX_PATTERN-1:0] in_eq;
   logic [MAX_PATTERN:0]   ok_chain;

   // control signals
   logic              csr_acc, adv, busy, acc;
   logic              window_ok, view_ok, drop_mode, pass_mode;
   logic [CW-1:0]     plen_sat, vfill;
   logic [IW-1:0]     fill_idx, load_pos;
   logic [LEN_W-1:0]  rlen_sat, match_len;
   logic [CNT_W-1:0]  found_inc, replaced_inc;
   logic              do_replace;
   logic [CFG_W-1:0]  burst_src;
   logic [BYTE_W-1:0] burst_byte;
   logic              emit, emit_bvalid, emit_end, text_done;
   logic [BYTE_W-1:0] emit_byte;
   logic              shift_win, load_win;

   assign csr_ready = 1'b1;
   assign csr_acc   = csr_valid & csr_ready;

   // configuration register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff    <= '0;
         pat_bytes_ff  <= '0;
         repl_len_ff   <= '0;
         repl_bytes_ff <= '0;
         start_ff      <= 24'd1;
         limit_ff      <= CNT_MAX;
      end else if (csr_acc) begin
         case (csr_index)
            REG_PAT_LEN:    pat_len_ff    <= csr_data[LEN_W-1:0];
            REG_PAT_BYTES:  pat_bytes_ff  <= csr_data;
            REG_REPL_LEN:   repl_len_ff   <= csr_data[LEN_W-1:0];
            REG_REPL_BYTES: repl_bytes_ff <= csr_data;
            REG_START:      start_ff      <= csr_data[CNT_W-1:0];
            REG_LIMIT:      limit_ff      <= csr_data[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // window cell chain
   assign ok_chain[0] = 1'b1;
   genvar g;
   generate
      for (g = 0; g < MAX_PATTERN; g++) begin : g_cell
         if (g == MAX_PATTERN - 1) begin : g_last
            assign right_byte[g] = '0;
         end else begin : g_mid
            assign right_byte[g] = cell_byte[g+1];
         end
         assign cell_valid[g]     = (fill_ff > CW'(g));
         assign cell_ctl[g].shift = shift_win;
         assign cell_ctl[g].load  = load_win & (load_pos == IW'(g));

         sfr_cell u_cell (
            .clock      (clock),
            .pat_byte   (pat_bytes_ff[g*BYTE_W +: BYTE_W]),
            .in_byte    (req_text_byte),
            .right_byte (right_byte[g]),
            .ctl        (cell_ctl[g]),
            .valid      (cell_valid[g]),
            .ok_in      (ok_chain[g]),
            .ok_out     (ok_chain[g+1]),
            .in_eq      (in_eq[g]),
            .byte_out   (cell_byte[g])
         );
      end
   endgenerate

   assign window_ok = ok_chain[MAX_PATTERN];

   // mode and match terms
   assign plen_sat  = (pat_len_ff > LEN_W'(MAX_PATTERN)) ? CW'(MAX_PATTERN) : CW'(pat_len_ff);
   assign rlen_sat  = (repl_len_ff > REPL_MAX) ? REPL_MAX : repl_len_ff;
   assign drop_mode = (start_ff == '0) || (limit_ff == '0);
   assign pass_mode = (plen_sat == '0) || skip_ff;
   assign fill_idx  = fill_ff[IW-1:0];
   assign vfill     = fill_ff + CW'(1);
   assign view_ok   = window_ok & in_eq[fill_idx];

   assign found_inc    = (found_ff == CNT_MAX) ? found_ff : found_ff + 24'd1;
   assign replaced_inc = (replaced_ff == CNT_MAX) ? replaced_ff : replaced_ff + 24'd1;
   assign do_replace   = (found_inc >= start_ff);
   assign match_len    = do_replace ? rlen_sat : LEN_W'(plen_sat);

   assign burst_src  = burst_repl_ff ? repl_bytes_ff : pat_bytes_ff;
   assign burst_byte = burst_src[{burst_idx_ff, 3'b000} +: BYTE_W];

   // handshake on the input side
   assign adv       = ~rsp_valid_ff | rsp_ready;
   assign busy      = (burst_left_ff != '0) | ~window_ok | end_pend_ff;
   assign req_ready = adv & ~busy;
   assign acc       = req_valid & req_ready;

   // one step of the match engine per cycle while the output register advances
   always_comb begin
      emit          = 1'b0;
      emit_byte     = '0;
      emit_bvalid   = 1'b1;
      emit_end      = 1'b0;
      text_done     = 1'b0;
      shift_win     = 1'b0;
      load_win      = 1'b0;
      load_pos      = fill_idx;
      fill_in       = fill_ff;
      burst_left_in = burst_left_ff;
      burst_idx_in  = burst_idx_ff;
      burst_repl_in = burst_repl_ff;
      end_pend_in   = end_pend_ff;
      found_in      = found_ff;
      replaced_in   = replaced_ff;
      skip_in       = skip_ff;

      if (adv) begin
         if (burst_left_ff != '0) begin
            // replacement or copied occurrence, one byte per cycle while the output is not stalled
            emit          = 1'b1;
            emit_byte     = burst_byte;
            burst_left_in = burst_left_ff - LEN_W'(1);
            burst_idx_in  = burst_idx_ff + 3'd1;
            if (end_pend_ff && (burst_left_ff == LEN_W'(1)) && (fill_ff == '0)) begin
               emit_end  = 1'b1;
               text_done = 1'b1;
            end
         end else if ((fill_ff != '0) && (~window_ok || end_pend_ff)) begin
            // release the head byte of the window
            emit      = 1'b1;
            emit_byte = cell_byte[0];
            shift_win = 1'b1;
            fill_in   = fill_ff - CW'(1);
            if (end_pend_ff && (fill_ff == CW'(1))) begin
               emit_end  = 1'b1;
               text_done = 1'b1;
            end
         end else if (acc) begin
            if (drop_mode) begin
               // everything dropped, only the bare end item
               if (req_text_end) begin
                  emit        = 1'b1;
                  emit_bvalid = 1'b0;
                  emit_end    = 1'b1;
                  text_done   = 1'b1;
               end
            end else if (pass_mode) begin
               emit      = 1'b1;
               emit_byte = req_text_byte;
               if (req_text_end) begin
                  emit_end  = 1'b1;
                  text_done = 1'b1;
               end
            end else if (view_ok && (vfill == plen_sat)) begin
               // full occurrence
               found_in      = found_inc;
               fill_in       = '0;
               burst_repl_in = do_replace;
               burst_idx_in  = 3'd1;
               if (do_replace) begin
                  replaced_in = replaced_inc;
                  if ((limit_ff != CNT_MAX) && (replaced_inc >= limit_ff)) begin
                     skip_in = 1'b1;
                  end
               end
               if (match_len != '0) begin
                  emit          = 1'b1;
                  emit_byte     = do_replace ? repl_bytes_ff[BYTE_W-1:0]
                                             : pat_bytes_ff[BYTE_W-1:0];
                  burst_left_in = match_len - LEN_W'(1);
               end
               if (req_text_end) begin
                  if (match_len > LEN_W'(1)) begin
                     end_pend_in = 1'b1;
                  end else if (match_len == LEN_W'(1)) begin
                     emit_end  = 1'b1;
                     text_done = 1'b1;
                  end else begin
                     emit        = 1'b1;
                     emit_bvalid = 1'b0;
                     emit_byte   = '0;
                     emit_end    = 1'b1;
                     text_done   = 1'b1;
                  end
               end
            end else if (view_ok && !req_text_end) begin
               // partial occurrence, hold the byte
               load_win = 1'b1;
               load_pos = fill_idx;
               fill_in  = vfill;
            end else begin
               // mismatch or final byte: release the head of the window, or the byte itself when empty
               emit = 1'b1;
               if (fill_ff == '0) begin
                  emit_byte = req_text_byte;
               end else begin
                  emit_byte = cell_byte[0];
                  shift_win = 1'b1;
                  load_win  = 1'b1;
                  load_pos  = fill_idx - IW'(1);
               end
               if (req_text_end) begin
                  if (fill_ff != '0) begin
                     end_pend_in = 1'b1;
                  end else begin
                     emit_end  = 1'b1;
                     text_done = 1'b1;
                  end
               end
            end
         end
      end

      // end of text or a configuration write returns the text state to reset
      if (text_done || csr_acc) begin
         fill_in       = '0;
         burst_left_in = '0;
         end_pend_in   = 1'b0;
         found_in      = '0;
         replaced_in   = '0;
         skip_in       = 1'b0;
      end
   end

   // text state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         burst_left_ff <= '0;
         burst_idx_ff  <= '0;
         burst_repl_ff <= 1'b0;
         end_pend_ff   <= 1'b0;
         found_ff      <= '0;
         replaced_ff   <= '0;
         skip_ff       <= 1'b0;
      end else begin
         fill_ff       <= fill_in;
         burst_left_ff <= burst_left_in;
         burst_idx_ff  <= burst_idx_in;
         burst_repl_ff <= burst_repl_in;
         end_pend_ff   <= end_pend_in;
         found_ff      <= found_in;
         replaced_ff   <= replaced_in;
         skip_ff       <= skip_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && emit) begin
         out_byte_ff   <= emit_byte;
         byte_valid_ff <= emit_bvalid;
         out_end_ff    <= emit_end;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_byte_valid = byte_valid_ff;
   assign rsp_out_end    = out_end_ff;

   // checks
   `SFR_CHECK(a_fill_below_depth, (fill_ff < CW'(MAX_PATTERN)), "window fill reached depth")
   `SFR_CHECK(a_burst_empty_window, ((burst_left_ff != '0) |-> (fill_ff == '0)), "burst with held bytes")
   `SFR_CHECK(a_skip_empty_window, (skip_ff |-> (fill_ff == '0)), "skip mode with held bytes")
   `SFR_CHECK(a_bare_is_end, ((rsp_valid_ff && !rsp_byte_valid) |-> rsp_out_end), "bare item without end")
   `SFR_CHECK_NEXT(a_end_clears, (adv && emit && emit_end), ((found_ff == '0) && !skip_ff && !end_pend_ff), "text state not cleared after end")

endmodule

[verif/tb_stream_find_replace_top.sv]
// testbench for stream_find_replace_top: directed and random texts against a local predictor
// depends on sfr_pkg and the stream_find_replace_top rtl; needs no other files
module tb_stream_find_replace_top;
   timeunit 1ns;
   timeprecision 1ps;
   import sfr_pkg::*;

   localparam int LATENCY     = 20;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 2000;
   localparam int RAND_ITEMS  = 500;
   // index with no register behind it, still clears the text in progress
   localparam logic [CSR_IW-1:0] REG_UNUSED = 3'd7;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              byte_valid;
      logic              out_end;
   } text_out_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CSR_IW-1:0]   csr_index = '0;
   logic [CFG_W-1:0]    csr_data = '0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [BYTE_W-1:0]   req_text_byte = '0;
   logic                req_text_end = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_byte_valid;
   logic                rsp_out_end;

   stream_find_replace_top dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_text_byte  (req_text_byte),
      .req_text_end   (req_text_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_out_end    (rsp_out_end)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor copy of the registers
   logic [LEN_W-1:0]  pat_len    = '0;
   logic [CFG_W-1:0]  pat_bytes  = '0;
   logic [LEN_W-1:0]  repl_len   = '0;
   logic [CFG_W-1:0]  repl_bytes = '0;
   logic [CNT_W-1:0]  start_occ  = 24'd1;
   logic [CNT_W-1:0]  repl_limit = CNT_MAX;

   // predictor per-text state
   logic [BYTE_W-1:0] win [8];
   int unsigned       win_fill = 0;
   bit                copy_rest = 1'b0;
   logic [CNT_W-1:0]  found_cnt = '0;
   logic [CNT_W-1:0]  replaced_cnt = '0;

   text_out_type rewritten_q [$];
   text_out_type want;
   int          idle_pct = 20;
   bit          hold_request = 1'b0;
   int unsigned hold_left = 0;
   int unsigned stall_cycles = 0;
   int unsigned mismatches = 0;
   int unsigned n_bytes = 0;
   int unsigned n_texts = 0;
   int unsigned n_checked = 0;
   int unsigned n_settings = 0;
   int unsigned rand_items = 0;

   function automatic text_out_type data_item(input logic [BYTE_W-1:0] v);
      text_out_type t;
      t.out_byte = v;
      t.byte_valid = 1'b1;
      t.out_end = 1'b0;
      return t;
   endfunction

   function automatic logic [CFG_W-1:0] pack_str(input string s);
      logic [CFG_W-1:0] v;
      v = '0;
      for (int i = 0; i < s.len() && i < 8; i++) v[i*8 +: 8] = s[i];
      return v;
   endfunction

   task automatic clear_text();
      for (int i = 0; i < 8; i++) win[i] = '0;
      win_fill = 0;
      copy_rest = 1'b0;
      found_cnt = '0;
      replaced_cnt = '0;
   endtask

   task automatic apply_reg(input logic [CSR_IW-1:0] idx, input logic [CFG_W-1:0] val);
      case (idx)
         REG_PAT_LEN:    pat_len = val[LEN_W-1:0];
         REG_PAT_BYTES:  pat_bytes = val;
         REG_REPL_LEN:   repl_len = val[LEN_W-1:0];
         REG_REPL_BYTES: repl_bytes = val;
         REG_START:      start_occ = val[CNT_W-1:0];
         REG_LIMIT:      repl_limit = val[CNT_W-1:0];
         default: ;
      endcase
      clear_text();
   endtask

   // output items caused by one accepted text byte
   task automatic rewrite_byte(input logic [BYTE_W-1:0] b, input logic last);
      text_out_type step_q [$];
      text_out_type tail;
      int unsigned plen, rlen, n, drop;
      bit          same;
      plen = (pat_len > 8) ? 8 : pat_len;
      rlen = (repl_len > REPL_MAX) ? REPL_MAX : repl_len;
      if (start_occ == 0 || repl_limit == 0) begin
         win_fill = 0;
      end else if (plen == 0 || copy_rest) begin
         for (int i = 0; i < win_fill; i++) step_q.push_back(data_item(win[i]));
         win_fill = 0;
         step_q.push_back(data_item(b));
      end else begin
         if (win_fill < 8) begin
            win[win_fill] = b;
            win_fill++;
         end
         // resolve the window until it holds only a pattern prefix
         while (win_fill > 0) begin
            n = (win_fill < plen) ? win_fill : plen;
            same = 1'b1;
            for (int i = 0; i < n; i++)
               if (win[i] != pat_bytes[i*8 +: 8]) same = 1'b0;
            if (same && n < plen) break;
            if (same) begin
               if (found_cnt != CNT_MAX) found_cnt++;
               if (found_cnt >= start_occ) begin
                  for (int i = 0; i < rlen; i++)
                     step_q.push_back(data_item(repl_bytes[i*8 +: 8]));
                  if (replaced_cnt != CNT_MAX) replaced_cnt++;
                  if (repl_limit != CNT_MAX && replaced_cnt >= repl_limit) copy_rest = 1'b1;
               end else begin
                  for (int i = 0; i < plen; i++) step_q.push_back(data_item(win[i]));
               end
               drop = plen;
            end else begin
               step_q.push_back(data_item(win[0]));
               drop = 1;
            end
            for (int i = 0; i + drop < win_fill; i++) win[i] = win[i + drop];
            win_fill -= drop;
         end
      end
      // end of text: flush held bytes and mark the last item
      if (last) begin
         if (start_occ != 0 && repl_limit != 0)
            for (int i = 0; i < win_fill; i++) step_q.push_back(data_item(win[i]));
         if (step_q.size() == 0) begin
            tail = '0;
         end else begin
            tail = step_q.pop_back();
         end
         tail.out_end = 1'b1;
         step_q.push_back(tail);
         clear_text();
      end
      foreach (step_q[i]) rewritten_q.push_back(step_q[i]);
   endtask

   // send one text byte; entered and left just after a falling edge
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= b;
      req_text_end <= last;
      do @(posedge clock); while (!req_ready);
      rewrite_byte(b, last);
      n_bytes++;
      if (last) n_texts++;
      @(negedge clock);
   endtask

   task automatic send_str(input string s, input bit with_end);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], with_end && i == s.len() - 1);
   endtask

   // registers change only once the block has drained
   task automatic write_reg(input logic [CSR_IW-1:0] idx, input logic [CFG_W-1:0] val);
      req_valid <= 1'b0;
      while (rewritten_q.size() != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [CFG_W-1:0] plen, input logic [CFG_W-1:0] pat,
                             input logic [CFG_W-1:0] rlen, input logic [CFG_W-1:0] repl,
                             input logic [CFG_W-1:0] start, input logic [CFG_W-1:0] limit);
      write_reg(REG_PAT_LEN, plen);
      write_reg(REG_PAT_BYTES, pat);
      write_reg(REG_REPL_LEN, rlen);
      write_reg(REG_REPL_BYTES, repl);
      write_reg(REG_START, start);
      write_reg(REG_LIMIT, limit);
      n_settings++;
   endtask

   // reset defaults: empty pattern copies every byte
   task automatic test_pass_through();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   // leftmost non-overlapping matches, partial match released by a mismatch
   task automatic test_replace_overlap();
      set_config(3, pack_str("aba"), 2, pack_str("<>"), 1, CNT_MAX);
      send_str("ababax", 1'b1);
   endtask

   // zero-length replacement: empty text output, held byte flushed at text end
   task automatic test_delete_and_flush();
      set_config(2, pack_str("zz"), 0, {CFG_W{1'b1}}, 1, CNT_MAX);
      send_str("zz", 1'b1);
      send_str("az", 1'b1);
   endtask

   // start occurrence and replace limit, then each set to zero
   task automatic test_start_and_limit();
      set_config(1, pack_str("a"), 1, pack_str("B"), 2, 1);
      send_str("aaaa", 1'b1);
      write_reg(REG_START, 0);
      send_str("q", 1'b1);
      write_reg(REG_START, 1);
      write_reg(REG_LIMIT, 0);
      send_str("a", 1'b1);
   endtask

   // length fields above eight are clamped to eight
   task automatic test_length_saturation();
      set_config(15, pack_str("01234567"), 12, pack_str("ABCDEFGH"), 1, CNT_MAX);
      send_str("01234567", 1'b1);
   endtask

   // a register write in mid-text drops the held bytes
   task automatic test_abandoned_text();
      set_config(2, pack_str("ab"), 1, pack_str("*"), 1, CNT_MAX);
      send_byte("a", 1'b0);
      write_reg(REG_UNUSED, '0);
      send_str("b", 1'b1);
   endtask

   // long receiver stall while every byte expands to eight
   task automatic test_output_backpressure();
      set_config(1, pack_str("a"), 8, pack_str("12345678"), 1, CNT_MAX);
      hold_request = 1'b1;
      for (int i = 0; i < 24; i++) send_byte("a", i == 23);
   endtask

   // random settings, texts built mostly from whole and partial pattern copies
   task automatic test_random_texts();
      logic [BYTE_W-1:0] alph [4];
      logic [BYTE_W-1:0] txt [$];
      logic [CFG_W-1:0]  pat, plen_f, rlen_f, start_v, limit_v;
      int unsigned       phase, plen_use, r, k, tlen, phase_len, n;
      bit                open_text;
      phase = 0;
      while (rand_items < RAND_ITEMS) begin
         for (int i = 0; i < 4; i++) alph[i] = $urandom_range(255);
         pat = {$urandom, $urandom};
         for (int i = 0; i < 8; i++) pat[i*8 +: 8] = alph[$urandom_range(3)];
         r = $urandom_range(99);
         plen_f = (r < 10) ? 0 : (r < 20) ? $urandom_range(15, 9) : (r < 30) ? 8 :
                  $urandom_range(4, 1);
         r = $urandom_range(99);
         rlen_f = (r < 15) ? 0 : (r < 25) ? $urandom_range(15, 9) : (r < 35) ? 8 :
                  $urandom_range(4, 1);
         r = $urandom_range(99);
         start_v = (r < 8) ? 0 : (r < 15) ? CNT_MAX : (r < 20) ? $urandom_range(CNT_MAX, 4) :
                   $urandom_range(3, 1);
         r = $urandom_range(99);
         limit_v = (r < 8) ? 0 : (r < 40) ? CNT_MAX : (r < 45) ? $urandom_range(CNT_MAX, 4) :
                   $urandom_range(3, 1);
         set_config(plen_f, pat, rlen_f, {$urandom, $urandom}, start_v, limit_v);
         idle_pct = (phase == 3) ? 0 : 20;
         plen_use = (plen_f == 0) ? 3 : (plen_f > 8) ? 8 : plen_f;
         phase_len = $urandom_range(60, 30);
         n = 0;
         while (n < phase_len) begin
            // one text
            txt.delete();
            tlen = $urandom_range(20, 1);
            while (txt.size() < tlen) begin
               r = $urandom_range(99);
               if (r < 50) begin
                  for (int i = 0; i < plen_use; i++) txt.push_back(pat[i*8 +: 8]);
               end else if (r < 65) begin
                  k = $urandom_range(plen_use, 1);
                  for (int i = 0; i < k; i++) txt.push_back(pat[i*8 +: 8]);
               end else if (r < 90) begin
                  txt.push_back(alph[$urandom_range(3)]);
               end else begin
                  txt.push_back($urandom_range(255));
               end
            end
            // the last text of a phase is sometimes left open
            open_text = (n + txt.size() >= phase_len) && ($urandom_range(99) < 20);
            foreach (txt[i]) send_byte(txt[i], !open_text && i == txt.size() - 1);
            n += txt.size();
            rand_items += txt.size();
         end
         phase++;
      end
      idle_pct = 20;
   endtask

   // receiver: random ready, or a long hold when requested
   always @(negedge clock) begin
      if (hold_request && hold_left == 0) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // compare each output item with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         n_checked++;
         if (rewritten_q.size() == 0) begin
            mismatches++;
            $display("%0t: expected nothing, got byte %02h valid %b end %b",
                     $time, rsp_out_byte, rsp_byte_valid, rsp_out_end);
         end else begin
            want = rewritten_q.pop_front();
            if (want.out_byte !== rsp_out_byte || want.byte_valid !== rsp_byte_valid ||
                want.out_end !== rsp_out_end) begin
               mismatches++;
               $display("%0t: expected byte %02h valid %b end %b, got byte %02h valid %b end %b",
                        $time, want.out_byte, want.byte_valid, want.out_end,
                        rsp_out_byte, rsp_byte_valid, rsp_out_end);
            end
         end
      end
   end

   // watchdog on cycles in which no item moves on any channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no item moved for %0d cycles, %0d output items outstanding",
                  $time, stall_cycles, rewritten_q.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_pass_through();
      test_replace_overlap();
      test_delete_and_flush();
      test_start_and_limit();
      test_length_saturation();
      test_abandoned_text();
      test_output_backpressure();
      test_random_texts();
      req_valid <= 1'b0;
      while (rewritten_q.size() != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
      $display("sent %0d text bytes in %0d texts over %0d register settings",
               n_bytes, n_texts, n_settings);
      $display("checked %0d output items, %0d mismatching", n_checked, mismatches);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+sv
sv/sfr_pkg.sv
sv/sfr_cell.sv
sv/stream_find_replace_top.sv
verif/tb_stream_find_replace_top.sv
